// File: design/qfts_pkg.sv
// shared types and constants of the two-stack queue
// no dependencies; imported by qfts_stack_ram and queue_from_two_stacks_unit
package qfts_pkg;

    localparam int DATA_W        = 32;
    localparam int CAP_W         = 5;
    localparam int DEPTH_DEFAULT = 16;
    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
    localparam logic [DATA_W-1:0] DATA_UNDERFLOW = '1;
    localparam logic [DATA_W-1:0] DATA_NONE = '0;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_POP,
        S_WAIT,
        S_HOLD
    } t_state;

endpackage

// File: design/queue_from_two_stacks_unit.sv
// first-in first-out queue built from an inbox and an outbox stack. An insert
// is answered from the idle state. A remove from a non-empty outbox reads the
// outbox memory and answers from the wait state, as the outbox read data is
// registered. A remove that finds the outbox empty first moves the n inbox
// entries across, one per cycle through the single inbox read port, then pops
// the outbox; the moved entries then serve later removes from the outbox. An
// underflow answer is given from the idle state. The result register lets the
// next request in while the last result still waits; a further result then
// waits in a holding register. Depends on qfts_pkg and qfts_stack_ram.
module queue_from_two_stacks_unit
    import qfts_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] data_in
    input  logic              s_axis_tuser,   // [0] cmd
    // result channel
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] data_out
    output logic [1:0]        m_axis_tuser,   // [1:0] status
    // capacity register write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CAP_W-1:0]  i_cfg_data
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    t_state            r_state, n_state;
    logic [CAP_W-1:0]  r_cap;
    logic [CW-1:0]     r_in_cnt, n_in_cnt;
    logic [CW-1:0]     r_out_cnt, n_out_cnt;
    logic              r_mv_pend, n_mv_pend;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_data, n_out_data;
    t_status           r_out_status, n_out_status;
    logic [DATA_W-1:0] r_hold_data, n_hold_data;
    t_status           r_hold_status, n_hold_status;

    logic              in_we, in_re, out_we, out_re;
    logic [AW-1:0]     in_raddr, out_raddr;
    logic [DATA_W-1:0] in_rdata, out_rdata;
    logic [CW-1:0]     in_top, out_top;
    logic              in_full, out_free, req_take;
    logic              res_emit;
    logic [DATA_W-1:0] res_data;
    t_status           res_status;

    assign in_top    = r_in_cnt - CW'(1);
    assign out_top   = r_out_cnt - CW'(1);
    assign in_full   = (CMPW'(r_in_cnt) >= CMPW'(r_cap)) || (r_in_cnt >= CW'(DEPTH));
    assign out_free  = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign req_take      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    qfts_stack_ram #(.DEPTH(DEPTH), .AW(AW)) u_inbox (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (r_in_cnt[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (in_re),
        .i_raddr (in_raddr),
        .o_rdata (in_rdata)
    );

    qfts_stack_ram #(.DEPTH(DEPTH), .AW(AW)) u_outbox (
        .i_clk   (i_clk),
        .i_we    (out_we),
        .i_waddr (r_out_cnt[AW-1:0]),
        .i_wdata (in_rdata),
        .i_re    (out_re),
        .i_raddr (out_raddr),
        .o_rdata (out_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_in_cnt    <= '0;
            r_out_cnt   <= '0;
            r_mv_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_cnt    <= n_in_cnt;
            r_out_cnt   <= n_out_cnt;
            r_mv_pend   <= n_mv_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data    <= n_out_data;
        r_out_status  <= n_out_status;
        r_hold_data   <= n_hold_data;
        r_hold_status <= n_hold_status;
    end

    always_comb begin
        n_state       = r_state;
        n_in_cnt      = r_in_cnt;
        n_out_cnt     = r_out_cnt;
        n_mv_pend     = 1'b0;
        n_hold_data   = r_hold_data;
        n_hold_status = r_hold_status;
        in_we         = 1'b0;
        in_re         = 1'b0;
        in_raddr      = in_top[AW-1:0];
        out_we        = 1'b0;
        out_re        = 1'b0;
        out_raddr     = out_top[AW-1:0];
        res_emit      = 1'b0;
        res_data      = DATA_NONE;
        res_status    = ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (req_take) begin
                    if (t_cmd'(s_axis_tuser) == CMD_INSERT) begin
                        res_emit = 1'b1;
                        if (in_full) begin
                            res_status = ST_OVERFLOW;
                        end else begin
                            in_we    = 1'b1;
                            n_in_cnt = r_in_cnt + CW'(1);
                        end
                    end else if (r_out_cnt != '0) begin
                        out_re    = 1'b1;
                        n_out_cnt = out_top;
                        n_state   = S_WAIT;
                    end else if (r_in_cnt == '0) begin
                        res_emit   = 1'b1;
                        res_data   = DATA_UNDERFLOW;
                        res_status = ST_UNDERFLOW;
                    end else begin
                        n_state = S_MOVE;
                    end
                end
            end
            S_MOVE: begin
                // read inbox newest first, write outbox from the bottom on the next cycle
                if (r_mv_pend) begin
                    out_we    = 1'b1;
                    n_out_cnt = r_out_cnt + CW'(1);
                end
                if (r_in_cnt != '0) begin
                    in_re     = 1'b1;
                    n_in_cnt  = in_top;
                    n_mv_pend = 1'b1;
                end else begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                out_re    = 1'b1;
                n_out_cnt = out_top;
                n_state   = S_WAIT;
            end
            S_WAIT: begin
                res_emit   = 1'b1;
                res_data   = out_rdata;
                res_status = ST_OK;
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (res_emit) begin
            n_state = out_free ? S_IDLE : S_HOLD;
            if (!out_free) begin
                n_hold_data   = res_data;
                n_hold_status = res_status;
            end
        end
    end

    // result register: loads a new result or the held one once it is free
    always_comb begin
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        if (res_emit && out_free) begin
            n_out_valid  = 1'b1;
            n_out_data   = res_data;
            n_out_status = res_status;
        end else if (r_state == S_HOLD && out_free) begin
            n_out_valid  = 1'b1;
            n_out_data   = r_hold_data;
            n_out_status = r_hold_status;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_cnt <= CW'(DEPTH)) && (r_out_cnt <= CW'(DEPTH)))
        else $error("stack count beyond depth");

    a_pop_after_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_out_cnt != '0) && (r_in_cnt == '0))
        else $error("pop after transfer with empty outbox or leftover inbox");

    a_underflow_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_UNDERFLOW) |-> (r_out_data == DATA_UNDERFLOW))
        else $error("underflow result without all-ones data");

    a_move_starts_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && $past(r_state) == S_IDLE && r_state != S_MOVE) ##1
        (r_state == S_MOVE) |-> ($past(r_out_cnt) == '0))
        else $error("transfer started with a non-empty outbox");
`endif

endmodule

// File: design/qfts_stack_ram.sv
// single-port-write, single-port-read synchronous memory holding one stack
// read data is registered; depends on qfts_pkg
module qfts_stack_ram
    import qfts_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
